FILE: src/b2b_pkg.sv
// b2b_pkg: shared types and constants for the BLAKE2b-256 single-block core.
// No dependencies.
package b2b_pkg;

	typedef struct packed {
		logic [63:0] msg_word;
		logic        last_word;
		logic [7:0]  msg_length;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0]  digest_index;
		logic        last_result;
		logic        too_long;
	} out_beat_t;

	// job handed from front to back: masked message block plus length
	typedef struct packed {
		logic [15:0][63:0] msg;
		logic [7:0]        len;
		logic              err;
	} job_t;

	localparam int unsigned MSG_WORDS = 16;
	localparam int unsigned MAX_BYTES = 128;
	localparam logic [63:0] PARAM_WORD = 64'h0000_0000_0101_0020;

	localparam logic [7:0][63:0] IV = {
		64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b,
		64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
		64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b,
		64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908};

	// message schedule, returns word index for round r, slot k
	function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] k);
		logic [63:0] row;
		case (r)
			4'd0: row = 64'hFEDCBA9876543210;
			4'd1: row = 64'h357B20C16DF984AE;
			4'd2: row = 64'h491763EADF250C8B;
			4'd3: row = 64'h8F04A562EBCD1397;
			4'd4: row = 64'hD386CB1EFA427509;
			4'd5: row = 64'h91EF57D438B0A6C2;
			4'd6: row = 64'hB8293670A4DEF15C;
			4'd7: row = 64'hA2684F05931CE7BD;
			4'd8: row = 64'h5A417D2C803B9EF6;
			4'd9: row = 64'h0DC3E9BF5167482A;
			default: row = 64'hFEDCBA9876543210;
		endcase
		return row[k*4 +: 4];
	endfunction

endpackage

FILE: src/b2b_front.sv
// b2b_front: gathers message words, masks tail bytes, flags overflow.
// Uses b2b_pkg.
module b2b_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  b2b_pkg::in_beat_t in_data,
	output logic             job_valid,
	input  logic             job_take,
	output b2b_pkg::job_t    job
);
	logic [15:0][63:0] store_q;
	logic [4:0]        cnt_q;
	logic              ovf_q;
	logic              jv_q;
	b2b_pkg::job_t     job_q;
	logic              acc;
	logic [15:0][63:0] cur;
	logic              ovf_n;

	assign in_stall  = jv_q;
	assign acc       = in_valid && !jv_q;
	assign job_valid = jv_q;
	assign job       = job_q;

	always_comb begin
		cur   = store_q;
		ovf_n = ovf_q;
		if (cnt_q[4]) ovf_n = 1'b1;
		else cur[cnt_q[3:0]] = in_data.msg_word;
		for (int i = 0; i < 16; i++)
			for (int k = 0; k < 8; k++)
				if (9'(i*8+k) >= {1'b0, in_data.msg_length}) cur[i][k*8 +: 8] = 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			jv_q    <= 1'b0;
		end else begin
			if (job_take) jv_q <= 1'b0;
			if (acc) begin
				if (in_data.last_word) begin
					store_q <= '0;
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					jv_q    <= 1'b1;
				end else begin
					if (cnt_q[4]) ovf_q <= 1'b1;
					else begin
						store_q[cnt_q[3:0]] <= in_data.msg_word;
						cnt_q <= cnt_q + 5'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && in_data.last_word) begin
			job_q.msg <= cur;
			job_q.len <= in_data.msg_length;
			job_q.err <= ovf_n || (in_data.msg_length > 8'(b2b_pkg::MAX_BYTES));
		end
	end
endmodule

FILE: src/b2b_back.sv
// b2b_back: 12-round compression, one G function per cycle, then digest output.
// Uses b2b_pkg.
module b2b_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_take,
	input  b2b_pkg::job_t     job,
	output logic              out_valid,
	input  logic              out_stall,
	output b2b_pkg::out_beat_t out_data
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} st_t;

	st_t               st_q;
	logic [15:0][63:0] v_q;
	logic [15:0][63:0] m_q;
	logic              err_q;
	logic [3:0]        rnd_q;
	logic [2:0]        g_q;
	logic [1:0]        idx_q;
	logic [3:0] ia, ib, ic, id, sx, sy;
	logic [63:0] a, b, c, d;
	logic [3:0]  srow;
	logic [15:0][63:0] vinit;

	always_comb begin
		case (g_q)
			3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
			3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
			3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
			3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
			3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
			3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
			3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
			default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
		endcase
		srow = (rnd_q >= 4'd10) ? rnd_q - 4'd10 : rnd_q;
		sx = b2b_pkg::sigma(srow, {g_q, 1'b0});
		sy = b2b_pkg::sigma(srow, {g_q, 1'b1});
		a = v_q[ia]; b = v_q[ib]; c = v_q[ic]; d = v_q[id];
		a = a + b + m_q[sx];
		d = d ^ a; d = {d[31:0], d[63:32]};
		c = c + d;
		b = b ^ c; b = {b[23:0], b[63:24]};
		a = a + b + m_q[sy];
		d = d ^ a; d = {d[15:0], d[63:16]};
		c = c + d;
		b = b ^ c; b = {b[62:0], b[63]};
		for (int i = 0; i < 8; i++) begin
			vinit[i]   = b2b_pkg::IV[i];
			vinit[i+8] = b2b_pkg::IV[i];
		end
		vinit[0]  = vinit[0] ^ b2b_pkg::PARAM_WORD;
		vinit[12] = vinit[12] ^ {56'd0, job.len};
		vinit[14] = ~vinit[14];
	end

	assign job_take  = (st_q == ST_IDLE) && job_valid;
	assign out_valid = (st_q == ST_OUT);
	always_comb begin
		out_data.digest_index = err_q ? 2'd0 : idx_q;
		out_data.too_long     = err_q;
		out_data.last_result  = err_q || (idx_q == 2'd3);
		out_data.digest_word  = err_q ? 64'd0 :
			(b2b_pkg::IV[idx_q] ^ ((idx_q == 2'd0) ? b2b_pkg::PARAM_WORD : 64'd0)
			 ^ v_q[idx_q] ^ v_q[{2'b10, idx_q}]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			rnd_q <= '0;
			g_q   <= '0;
			idx_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: if (job_valid) begin
					rnd_q <= '0; g_q <= '0; idx_q <= '0;
					st_q  <= job.err ? ST_OUT : ST_RUN;
				end
				ST_RUN: begin
					g_q <= g_q + 3'd1;
					if (g_q == 3'd7) begin
						rnd_q <= rnd_q + 4'd1;
						if (rnd_q == 4'd11) st_q <= ST_OUT;
					end
				end
				ST_OUT: if (!out_stall) begin
					idx_q <= idx_q + 2'd1;
					if (err_q || idx_q == 2'd3) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			v_q   <= vinit;
			m_q   <= job.msg;
			err_q <= job.err;
		end else if (st_q == ST_RUN) begin
			v_q[ia] <= a; v_q[ib] <= b; v_q[ic] <= c; v_q[id] <= d;
		end
	end
endmodule

FILE: src/blake2b_256_single_block_core.sv
// blake2b_256_single_block_core: unkeyed BLAKE2b-256 over one final block.
// Uses b2b_pkg, b2b_front, b2b_back.
//
// Input channel (in_valid/in_stall/in_data): one 64-bit little-endian message
// word per beat; last_word marks the final beat, whose msg_length gives the
// total byte count. Words beyond the sixteenth are dropped and flag an error.
// Non-final words are taken one per cycle unless a finished job awaits hand-off.
// Output channel (out_valid/out_stall/out_data): four beats, digest_index 0..3,
// last_result on the fourth; or one error beat (too_long, zero digest) when the
// length exceeds 128 bytes or a seventeenth word was sent.
// After the final word the job passes the hand-off register; the back end then
// applies one G mixing function per cycle, 8 per round over 12 rounds, before
// it offers the first digest beat. An error beat is offered the cycle after hand-off.
// The front holds one finished job in its hand-off register, so the next
// message can load while the back end compresses; while a finished job waits in
// that register, the front stalls every beat until the back end takes it.
// A stalled output beat holds; the compression unit waits with it.
// Reset (arst_n low) clears the word store, counters and both state machines.
module blake2b_256_single_block_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  b2b_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output b2b_pkg::out_beat_t out_data
);
	logic          job_valid;
	logic          job_take;
	b2b_pkg::job_t job;

	b2b_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.job_valid, .job_take, .job
	);

	b2b_back u_back (
		.clk, .arst_n, .job_valid, .job_take, .job,
		.out_valid, .out_stall, .out_data
	);

	// a job is only taken when one is offered
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid) else $error("job taken without valid");

	// error beats are always final and carry a zero digest
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.too_long) |->
		(out_data.last_result && out_data.digest_word == 64'd0))
		else $error("bad error beat");

	// output beat holds under stall
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled beat changed");
endmodule

FILE: verif/tb_blake2b_256_single_block_core.sv
// Self-checking bench for blake2b_256_single_block_core: BLAKE2b-256 digests
// predicted in SV from message beats and checked beat by beat. Needs b2b_pkg.

// Digest predictor and queue of expected output beats.
class b2b_digest_board;
	logic [15:0][63:0] words;
	int unsigned       nwords;
	bit                overflow;
	b2b_pkg::out_beat_t pending[$];
	int unsigned       mismatches;

	static function logic [63:0] ror(logic [63:0] x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	static function int sched(int r, int k);
		int rows[10][16] = '{
			'{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
			'{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
			'{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
			'{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
			'{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
			'{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
			'{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
			'{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
			'{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
			'{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};
		return rows[r][k];
	endfunction

	function void clear();
		words = '0;
		nwords = 0;
		overflow = 0;
	endfunction

	function void note_beat(b2b_pkg::in_beat_t b);
		logic [63:0] iv[8] = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
			64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1, 64'h510e527fade682d1,
			64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
		int gi[8][4] = '{'{0, 4, 8, 12}, '{1, 5, 9, 13}, '{2, 6, 10, 14},
			'{3, 7, 11, 15}, '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7, 8, 13},
			'{3, 4, 9, 14}};
		logic [63:0] m[16];
		logic [63:0] v[16];
		logic [63:0] h0;
		b2b_pkg::out_beat_t o;
		int ia, ib, ic, id;
		if (nwords < 16) begin
			words[nwords] = b.msg_word;
			nwords++;
		end else begin
			overflow = 1;
		end
		if (!b.last_word)
			return;
		if (overflow || b.msg_length > 128) begin
			o = '0;
			o.last_result = 1;
			o.too_long = 1;
			pending.push_back(o);
			clear();
			return;
		end
		// mask bytes at or past the length
		for (int i = 0; i < 16; i++) begin
			m[i] = words[i];
			for (int k = 0; k < 8; k++)
				if (i * 8 + k >= b.msg_length)
					m[i][8*k +: 8] = 8'h00;
		end
		h0 = iv[0] ^ 64'h01010020;
		for (int i = 0; i < 8; i++) begin
			v[i] = (i == 0) ? h0 : iv[i];
			v[i+8] = iv[i];
		end
		v[12] ^= 64'(b.msg_length);
		v[14] = ~v[14];
		for (int r = 0; r < 12; r++)
			for (int g = 0; g < 8; g++) begin
				ia = gi[g][0]; ib = gi[g][1]; ic = gi[g][2]; id = gi[g][3];
				v[ia] = v[ia] + v[ib] + m[sched(r % 10, 2*g)];
				v[id] = ror(v[id] ^ v[ia], 32);
				v[ic] = v[ic] + v[id];
				v[ib] = ror(v[ib] ^ v[ic], 24);
				v[ia] = v[ia] + v[ib] + m[sched(r % 10, 2*g+1)];
				v[id] = ror(v[id] ^ v[ia], 16);
				v[ic] = v[ic] + v[id];
				v[ib] = ror(v[ib] ^ v[ic], 63);
			end
		for (int i = 0; i < 4; i++) begin
			o.digest_word = ((i == 0) ? h0 : iv[i]) ^ v[i] ^ v[i+8];
			o.digest_index = 2'(i);
			o.last_result = (i == 3);
			o.too_long = 0;
			pending.push_back(o);
		end
		clear();
	endfunction

	function void check_beat(b2b_pkg::out_beat_t got);
		b2b_pkg::out_beat_t want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected digest beat %h", got);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("digest beat mismatch: exp word %h idx %0d last %b err %b, got word %h idx %0d last %b err %b",
					want.digest_word, want.digest_index, want.last_result, want.too_long,
					got.digest_word, got.digest_index, got.last_result, got.too_long);
		end
	endfunction
endclass

module tb_blake2b_256_single_block_core;

	localparam int CYCLE_LIMIT = 400000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	b2b_pkg::in_beat_t  in_data = '0;
	logic               out_valid;
	logic               out_stall = 0;
	b2b_pkg::out_beat_t out_data;

	// idle percentages for the sender and the receiver, set per phase
	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;
	int unsigned cycles = 0;
	b2b_digest_board board = new();

	blake2b_256_single_block_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #2 clk = ~clk;

	// receiver: check accepted beats, then pick next stall
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall)
			board.check_beat(out_data);
		out_stall <= ($urandom_range(99) < recv_stall);
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_blake2b_256_single_block_core NOT OK");
			$finish;
		end
	end

	// one beat: optional idle gaps, then hold until accepted
	task automatic send_beat(logic [63:0] w, logic lst, logic [7:0] len);
		b2b_pkg::in_beat_t b;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		b.msg_word = w;
		b.last_word = lst;
		b.msg_length = len;
		in_valid <= 1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		board.note_beat(b);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom(), $urandom()};
	endfunction

	// a message of nw words, each beat carrying the length len
	task automatic send_msg(int nw, int len);
		for (int i = 0; i < nw; i++)
			send_beat(rnd64(), i == nw - 1, 8'(len));
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	int nw, len, items;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty, extremes, masking, length past words, errors
		send_beat('0, 1, 8'd0);
		send_beat('1, 1, 8'd8);
		send_beat('1, 1, 8'd3);
		send_beat('1, 1, 8'd128);            // one word, length far beyond it
		send_msg(16, 128);
		send_msg(16, 127);
		send_msg(2, 9);
		send_beat('1, 1, 8'd129);            // too long
		send_beat('0, 1, 8'd255);
		send_msg(17, 100);                   // seventeenth word marked last
		for (int i = 0; i < 18; i++)         // overflow, then final later
			send_beat('1, i == 17, 8'd5);
		drain();                             // sender waits for all results

		items = 0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 72; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 72; end
				3: begin send_idle = 29; recv_stall = 29; end
				default: begin send_idle = 0; recv_stall = 0; end
			endcase
			while (items < 67 * (ph + 1)) begin
				nw = $urandom_range(1, 16);
				case ($urandom_range(9))
					0: len = $urandom_range(129, 255);
					1: begin nw = $urandom_range(17, 19); len = $urandom_range(0, 128); end
					2: len = $urandom_range(0, 128);
					default: len = $urandom_range(nw * 8 - 7, nw * 8);
				endcase
				send_msg(nw, len);
				items += nw;
			end
		end
		drain();
		repeat (300) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb_blake2b_256_single_block_core OK");
		else
			$display("tb_blake2b_256_single_block_core NOT OK");
		$finish;
	end
endmodule
